[rtl/mqttfh_pkg.sv]
// Shared types and constants for the MQTT fixed-header deframer.
// No dependencies; compile first.
`timescale 1ns / 1ps

package mqttfh_pkg;

    localparam int BYTE_W            = 8;
    localparam int LEN_W             = 28;
    localparam int CNT_W             = 3;
    localparam int SHIFT_W           = 5;
    localparam int MAX_LEN_BYTES_DEF = 4;

    // bit position of each 7-bit length group
    localparam logic [SHIFT_W-1:0] LEN_SHIFT [4] = '{5'd0, 5'd7, 5'd14, 5'd21};

    typedef enum logic [1:0] {
        PH_FIRST   = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_SKIP    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_HDR_TRUNC = 2'd0,
        ERR_ZERO_LEN  = 2'd1,
        ERR_LEN_OVER  = 2'd2,
        ERR_PAY_TRUNC = 2'd3
    } err_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              buffer_end;
    } in_word_t;

    typedef struct packed {
        kind_t             kind;
        logic [3:0]        packet_type;
        logic [3:0]        packet_flags;
        logic [LEN_W-1:0]  rem_length;
        logic [BYTE_W-1:0] payload_byte;
        err_t              error_code;
        logic              packet_last;
    } out_word_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } result_t;

endpackage

[rtl/mqttfh_stream_if.sv]
// Valid/ready stream channel used for the input and output words.
// Payload type is a parameter; types come from mqttfh_pkg.
`timescale 1ns / 1ps

interface mqttfh_stream_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/mqtt_fixed_header_deframer.sv]
// MQTT fixed-header deframer: one buffer byte per input word.
// A result word, if any, is valid in the cycle after its input word is accepted.
// Throughput: one input word per cycle unless egress stalls; the output register frees itself in
// the same cycle it is taken, so ingress.ready = !out_valid || egress.ready.
// Reset (rst_n low, async) returns to the first-header-byte phase and empties
// the output register. Depends on mqttfh_pkg, mqttfh_stream_if, mqttfh_parse.
`timescale 1ns / 1ps

module mqtt_fixed_header_deframer
    import mqttfh_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LEN_BYTES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    mqttfh_stream_if.sink   ingress,
    mqttfh_stream_if.source egress
);

    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;
    logic      accept;
    result_t   result;

    assign ingress.ready = !out_valid_reg || egress.ready;
    assign accept        = ingress.valid && ingress.ready;

    mqttfh_parse #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .in_word (ingress.payload),
        .result  (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (accept)
        begin
            out_valid_next = result.valid;
            out_word_next  = result.word;
        end
        else if (egress.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign egress.valid   = out_valid_reg;
    assign egress.payload = out_word_reg;

endmodule

[rtl/mqttfh_parse.sv]
// Parser state and single-pass step logic: one input word per step.
// Depends on mqttfh_pkg.
`timescale 1ns / 1ps

module mqttfh_parse
    import mqttfh_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LEN_BYTES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_word_t in_word,
    output result_t  result
);

    phase_t            phase_reg, phase_next;
    logic [3:0]        type_reg, type_next;
    logic [3:0]        flags_reg, flags_next;
    logic [LEN_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  left_reg, left_next;

    logic [BYTE_W-1:0] b;
    logic              last_in;
    logic              cont;
    logic [LEN_W-1:0]  len_piece;
    logic [LEN_W-1:0]  acc_sum;
    logic [CNT_W-1:0]  cnt_inc;
    logic              lim_hit;
    logic              acc_zero;
    logic [LEN_W-1:0]  left_dec;
    logic              left_zero;

    assign b         = in_word.data_byte;
    assign last_in   = in_word.buffer_end;
    assign cont      = b[BYTE_W-1];
    assign len_piece = LEN_W'(b[BYTE_W-2:0]) << LEN_SHIFT[count_reg[1:0]];
    assign acc_sum   = acc_reg + len_piece;
    assign cnt_inc   = count_reg + CNT_W'(1);
    assign lim_hit   = cnt_inc >= CNT_W'(MAX_LENGTH_BYTES);
    assign acc_zero  = (acc_sum == '0);
    assign left_dec  = left_reg - LEN_W'(1);
    assign left_zero = (left_dec == '0);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    phase_next = last_in ? PH_FIRST : PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    if (cont)
                    begin
                        if (lim_hit)
                            phase_next = last_in ? PH_FIRST : PH_SKIP;
                        else if (last_in)
                            phase_next = PH_FIRST;
                    end
                    else if (acc_zero)
                        phase_next = last_in ? PH_FIRST : PH_SKIP;
                    else if (last_in)
                        phase_next = PH_FIRST;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (left_zero)
                        phase_next = last_in ? PH_FIRST : PH_SKIP;
                    else if (last_in)
                        phase_next = PH_FIRST;
                end
                PH_SKIP:
                begin
                    if (last_in)
                        phase_next = PH_FIRST;
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        type_next  = type_reg;
        flags_next = flags_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        left_next  = left_reg;

        result.valid             = 1'b0;
        result.word.kind         = KIND_HEADER;
        result.word.rem_length   = '0;
        result.word.payload_byte = '0;
        result.word.error_code   = ERR_HDR_TRUNC;
        result.word.packet_last  = 1'b0;

        if (step)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    type_next  = b[7:4];
                    flags_next = b[3:0];
                    acc_next   = '0;
                    count_next = '0;
                    left_next  = '0;
                    if (last_in)
                    begin
                        result.valid            = 1'b1;
                        result.word.kind        = KIND_ERROR;
                        result.word.error_code  = ERR_HDR_TRUNC;
                        result.word.packet_last = 1'b1;
                    end
                end
                PH_LENGTH:
                begin
                    acc_next   = acc_sum;
                    count_next = cnt_inc;
                    if (cont)
                    begin
                        if (lim_hit || last_in)
                        begin
                            result.valid            = 1'b1;
                            result.word.kind        = KIND_ERROR;
                            result.word.error_code  = lim_hit ? ERR_LEN_OVER : ERR_HDR_TRUNC;
                            result.word.packet_last = 1'b1;
                        end
                    end
                    else if (acc_zero || last_in)
                    begin
                        result.valid            = 1'b1;
                        result.word.kind        = KIND_ERROR;
                        result.word.error_code  = acc_zero ? ERR_ZERO_LEN : ERR_PAY_TRUNC;
                        result.word.packet_last = 1'b1;
                    end
                    else
                    begin
                        left_next              = acc_sum;
                        result.valid           = 1'b1;
                        result.word.kind       = KIND_HEADER;
                        result.word.rem_length = acc_sum;
                    end
                end
                PH_PAYLOAD:
                begin
                    left_next    = left_dec;
                    result.valid = 1'b1;
                    if (!left_zero && last_in)
                    begin
                        result.word.kind        = KIND_ERROR;
                        result.word.error_code  = ERR_PAY_TRUNC;
                        result.word.packet_last = 1'b1;
                    end
                    else
                    begin
                        result.word.kind         = KIND_PAYLOAD;
                        result.word.payload_byte = b;
                        result.word.packet_last  = left_zero;
                    end
                end
                default:
                begin
                    // trailing bytes: no result
                end
            endcase
        end

        result.word.packet_type  = type_next;
        result.word.packet_flags = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            count_reg <= '0;
            type_reg  <= '0;
            flags_reg <= '0;
            acc_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            type_reg  <= type_next;
            flags_reg <= flags_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
        end
    end

endmodule

[rtl/mqttfh_chk.sv]
// Port-level checks for the deframer, attached by bind.
// Depends on mqttfh_pkg and mqtt_fixed_header_deframer.
`timescale 1ns / 1ps

module mqttfh_chk
    import mqttfh_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // an empty output register never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // a new result word needs an accepted input word
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result word without accepted input word");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.kind == KIND_ERROR |-> out_word.packet_last)
        else $error("error word without packet_last");

    a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.kind == KIND_HEADER
            |-> out_word.rem_length != '0 && !out_word.packet_last)
        else $error("header word with zero length or packet_last");

endmodule

bind mqtt_fixed_header_deframer mqttfh_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ingress.valid),
    .in_ready  (ingress.ready),
    .out_valid (egress.valid),
    .out_ready (egress.ready),
    .out_word  (egress.payload)
);
